// File: rtl/tges_pkg.sv
// ----------------------------------------------------------------------------
// tges_pkg
// Shared constants for the timed GPIO edge scheduler: widths, register
// indexes, command codes and reset values.
// ----------------------------------------------------------------------------
package tges_pkg;

  localparam int RING_DEPTH_DEF = 64;

  localparam int TIME_W  = 63;
  localparam int MASK_W  = 32;
  localparam int COUNT_W = 64;
  localparam int FILL_W  = 7;
  localparam int ENTRY_W = TIME_W + 2 * MASK_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PINS_DRIVEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARK_INTERVAL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CATCH_UP_LIMIT = 2'd3;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [MASK_W-1:0]  PARK_RESET     = 32'd1000;
  localparam logic [MASK_W-1:0]  CATCH_UP_RESET = 32'd200000;
  localparam logic [COUNT_W-1:0] ALARM_RESET    = 64'd1000;

endpackage

// File: rtl/tges_ram.sv
// ----------------------------------------------------------------------------
// tges_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tges_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/timed_gpio_edge_scheduler.sv
// ----------------------------------------------------------------------------
// timed_gpio_edge_scheduler
// Ring of timestamped output edges drained by timer ticks, with level,
// edge count, lateness and next-alarm tracking.
// ----------------------------------------------------------------------------
// channel   direction  transaction
// command   in         start & !busy; command, edge_time, masks, now_count
// result    out        done strobe, one cycle; accepted .. queue_fill
// config    in         cfg_write; cfg_index selects, cfg_data holds value
//
// Submit: result in the cycle after acceptance, busy stays low.
// Tick: an empty ring goes to the alarm state, else each fired edge passes
// the due, compare and lateness states; one due-time subtract and compare
// unit works one ring entry at a time, paced by the registered ring RAM read.
// Reset clears pointers, levels and statistics; the ring RAM is not cleared.
// Results cannot be stalled; done marks each one for exactly one cycle.
// ----------------------------------------------------------------------------
module timed_gpio_edge_scheduler #(
  parameter int RING_DEPTH = tges_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  output logic                               done,
  input  logic                               command,
  input  logic [tges_pkg::TIME_W-1:0]        edge_time,
  input  logic [tges_pkg::MASK_W-1:0]        set_mask,
  input  logic [tges_pkg::MASK_W-1:0]        clear_mask,
  input  logic [tges_pkg::COUNT_W-1:0]       now_count,
  output logic                               accepted,
  output logic [tges_pkg::MASK_W-1:0]        levels,
  output logic [tges_pkg::MASK_W-1:0]        pin_out,
  output logic [tges_pkg::MASK_W-1:0]        edges_applied,
  output logic [tges_pkg::MASK_W-1:0]        late_peak,
  output logic [tges_pkg::COUNT_W-1:0]       late_sum,
  output logic [tges_pkg::COUNT_W-1:0]       next_alarm,
  output logic [tges_pkg::FILL_W-1:0]        queue_fill,
  input  logic                               cfg_write,
  input  logic [tges_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tges_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import tges_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PW = $clog2(2 * RING_DEPTH);
  localparam int FW = (PW > FILL_W) ? PW : FILL_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);
  localparam logic [PW-1:0] MOD_P   = PW'(2 * RING_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(2 * RING_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_DUE   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_LATE  = 3'd4;
  localparam logic [2:0] S_ALARM = 3'd5;

  logic [2:0]         state;
  logic [TIME_W-1:0]  time_offset;
  logic               pins_driven;
  logic [MASK_W-1:0]  park_interval;
  logic [MASK_W-1:0]  catch_up_limit;

  logic [PW-1:0]      write_pointer;
  logic [PW-1:0]      read_pointer;
  logic [MASK_W-1:0]  level_bits;
  logic [MASK_W-1:0]  edge_total;
  logic [MASK_W-1:0]  lateness_max;
  logic [COUNT_W-1:0] lateness_sum;
  logic [COUNT_W-1:0] alarm_at;
  logic [COUNT_W-1:0] now_reg;
  logic [COUNT_W-1:0] due;
  logic [MASK_W-1:0]  late;
  logic               accepted_reg;
  logic               done_reg;

  logic [PW-1:0]      fill;
  logic [FW-1:0]      fill_ext;
  logic               full;
  logic               take;
  logic [AW-1:0]      wslot;
  logic [AW-1:0]      rslot;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]  rd_time;
  logic [MASK_W-1:0]  rd_set;
  logic [MASK_W-1:0]  rd_clear;
  logic [PW-1:0]      read_pointer_next;

  assign fill     = write_pointer - read_pointer +
                    ((write_pointer < read_pointer) ? MOD_P : '0);
  assign fill_ext = FW'(fill);
  assign full     = (fill >= DEPTH_P);
  assign take     = start && !busy;
  assign wslot    = (write_pointer >= DEPTH_P) ? AW'(write_pointer - DEPTH_P)
                                               : AW'(write_pointer);
  assign rslot    = (read_pointer >= DEPTH_P) ? AW'(read_pointer - DEPTH_P)
                                              : AW'(read_pointer);
  assign ram_we    = take && (command == CMD_SUBMIT) && !full;
  assign ram_wdata = {edge_time, set_mask, clear_mask};
  assign {rd_time, rd_set, rd_clear} = ram_rdata;
  assign read_pointer_next = (read_pointer == LAST_P) ? '0 : read_pointer + 1'b1;

  tges_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wslot),
    .wdata(ram_wdata),
    .raddr(rslot),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_offset    <= '0;
      pins_driven    <= 1'b1;
      park_interval  <= PARK_RESET;
      catch_up_limit <= CATCH_UP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_OFFSET:    time_offset    <= cfg_data;
        REG_PINS_DRIVEN:    pins_driven    <= cfg_data[0];
        REG_PARK_INTERVAL:  park_interval  <= cfg_data[MASK_W-1:0];
        REG_CATCH_UP_LIMIT: catch_up_limit <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      level_bits    <= '0;
      edge_total    <= '0;
      lateness_max  <= '0;
      lateness_sum  <= '0;
      alarm_at      <= ALARM_RESET;
      accepted_reg  <= 1'b0;
      done_reg      <= 1'b0;
    end else begin
      done_reg <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            if (command == CMD_SUBMIT) begin
              accepted_reg <= !full;
              done_reg     <= 1'b1;
              if (!full) begin
                write_pointer <= (write_pointer == LAST_P) ? '0
                                                           : write_pointer + 1'b1;
              end
            end else begin
              accepted_reg <= 1'b1;
              state        <= (fill == '0) ? S_ALARM : S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_DUE;
        end
        S_DUE: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (due > now_reg) begin
            alarm_at <= due;
            done_reg <= 1'b1;
            state    <= S_IDLE;
          end else begin
            level_bits   <= (level_bits | rd_set) & ~rd_clear;
            edge_total   <= edge_total + 1'b1;
            read_pointer <= read_pointer_next;
            state        <= S_LATE;
          end
        end
        S_LATE: begin
          if (late <= catch_up_limit) begin
            lateness_sum <= lateness_sum + COUNT_W'(late);
            if (late > lateness_max) begin
              lateness_max <= late;
            end
          end
          state <= (read_pointer == write_pointer) ? S_ALARM : S_DUE;
        end
        S_ALARM: begin
          alarm_at <= now_reg + COUNT_W'(park_interval);
          done_reg <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      now_reg <= now_count;
    end
    if (state == S_DUE) begin
      due <= {1'b0, rd_time} - {1'b0, time_offset};
    end
    if (state == S_CMP) begin
      late <= now_reg[MASK_W-1:0] - due[MASK_W-1:0];
    end
  end

  assign busy          = (state != S_IDLE);
  assign done          = done_reg;
  assign accepted      = accepted_reg;
  assign levels        = level_bits;
  assign pin_out       = pins_driven ? level_bits : '0;
  assign edges_applied = edge_total;
  assign late_peak     = lateness_max;
  assign late_sum      = lateness_sum;
  assign next_alarm    = alarm_at;
  assign queue_fill    = fill_ext[FILL_W-1:0];

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_P)
    else $error("ring fill above depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe while busy");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    (take && (command == CMD_SUBMIT) && full) |=> $stable(write_pointer))
    else $error("refused submit moved write pointer");

  a_head_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(rst)) |=> $stable(read_pointer))
    else $error("read pointer moved while idle");

  a_fire_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_LATE) |-> (edge_total == $past(edge_total) + 1'b1))
    else $error("fired edge not counted");
`endif

endmodule
